[sv/fir_decimator_assert.svh]
// Assertion macros for the FIR decimator.
// FIRD_ASSERT_IMP: same-cycle implication, FIRD_ASSERT_NXT: next-cycle implication.
// Both sample on clk_i and are off while rst_ni is low.
`ifndef FIR_DECIMATOR_ASSERT_SVH
`define FIR_DECIMATOR_ASSERT_SVH

`ifndef SYNTHESIS
`define FIRD_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("fir_decimator: check failed");
`define FIRD_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("fir_decimator: check failed");
`else
`define FIRD_ASSERT_IMP(label, ante, cons)
`define FIRD_ASSERT_NXT(label, ante, cons)
`endif

`endif

[sv/fird_pkg.sv]
`timescale 1ns / 1ps

package fird_pkg;

  localparam int MAX_TAPS     = 128;
  localparam int SAMPLE_WIDTH = 16;
  localparam int COEF_WIDTH   = 18;

  // fixed field and register widths
  localparam int CIDX_W     = 7;
  localparam int FACTOR_W   = 7;
  localparam int TAPS_REG_W = 8;
  localparam int PHASE_W    = 6;
  localparam int MAX_FACTOR = 64;

  localparam int IDX_W  = $clog2(MAX_TAPS);
  localparam int FILL_W = $clog2(MAX_TAPS + 1);
  localparam int CNT_W  = (FILL_W > TAPS_REG_W) ? FILL_W : TAPS_REG_W;

  localparam int PROD_W     = SAMPLE_WIDTH + COEF_WIDTH;
  localparam int ACC_W      = PROD_W + IDX_W + 1;
  localparam int FRAC_SHIFT = COEF_WIDTH - 2;

  // APB register file
  localparam int ADDR_W = 3;
  localparam int DATA_W = 32;

  localparam logic [0:0] REG_FACTOR = 1'b0;
  localparam logic [0:0] REG_TAPS   = 1'b1;

  localparam logic CMD_LOAD   = 1'b0;
  localparam logic CMD_SAMPLE = 1'b1;

  typedef logic signed [SAMPLE_WIDTH-1:0] sample_t;
  typedef logic signed [COEF_WIDTH-1:0]   coef_t;

  typedef struct packed {
    logic push;    // shift a new sample in at cell 0
    logic rotate;  // turn the ring one cell toward cell 0
  } cell_ctrl_t;

  typedef struct packed {
    logic en;      // a product is issued this cycle
    logic keep;    // tap is inside the active window
  } mac_issue_t;

endpackage

[sv/fird_in_if.sv]
`timescale 1ns / 1ps

interface fird_in_if import fird_pkg::*; ();
  logic                valid;
  logic                ready;
  logic                command;
  sample_t             sample_value;
  logic                first_of_signal;
  logic [CIDX_W-1:0]   coef_index;
  coef_t               coef_value;

  modport source (
    output valid, command, sample_value, first_of_signal, coef_index, coef_value,
    input  ready
  );

  modport sink (
    input  valid, command, sample_value, first_of_signal, coef_index, coef_value,
    output ready
  );
endinterface

[sv/fird_out_if.sv]
`timescale 1ns / 1ps

interface fird_out_if import fird_pkg::*; ();
  logic    valid;
  logic    ready;
  sample_t filtered_sample;
  logic    saturated;

  modport source (
    output valid, filtered_sample, saturated,
    input  ready
  );

  modport sink (
    input  valid, filtered_sample, saturated,
    output ready
  );
endinterface

[sv/fird_cell.sv]
`timescale 1ns / 1ps

// One tap of the ring: a delay-line sample and its coefficient.
module fird_cell import fird_pkg::*; (
  input  logic       clk_i,
  input  cell_ctrl_t ctrl_i,
  input  logic       load_i,
  input  coef_t      load_coef_i,
  input  sample_t    shift_sample_i,  // from the neighbor closer to the input
  input  sample_t    ring_sample_i,   // from the neighbor further along the ring
  input  coef_t      ring_coef_i,
  output sample_t    sample_o,
  output coef_t      coef_o
);

  sample_t sample_q;
  coef_t   coef_q;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.rotate) begin
      sample_q <= ring_sample_i;
      coef_q   <= ring_coef_i;
    end else begin
      if (ctrl_i.push) begin
        sample_q <= shift_sample_i;
      end
      if (load_i) begin
        coef_q <= load_coef_i;
      end
    end
  end

  assign sample_o = sample_q;
  assign coef_o   = coef_q;

endmodule

[sv/fird_mac.sv]
`timescale 1ns / 1ps

// Multiply at the ring head, accumulate, then round half up and saturate.
module fird_mac import fird_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       clr_i,
  input  mac_issue_t issue_i,
  input  sample_t    sample_i,
  input  coef_t      coef_i,
  output sample_t    result_o,
  output logic       saturated_o
);

  localparam int Q_W = ACC_W - FRAC_SHIFT + 1;

  localparam logic [ACC_W:0]          RND_HALF = (ACC_W + 1)'(1) << (FRAC_SHIFT - 1);
  localparam logic signed [Q_W-1:0]   SAT_HI   = Q_W'(2 ** (SAMPLE_WIDTH - 1) - 1);
  localparam logic signed [Q_W-1:0]   SAT_LO   = Q_W'(-(2 ** (SAMPLE_WIDTH - 1)));

  logic signed [PROD_W-1:0] prod_w;
  logic signed [PROD_W-1:0] prod_q;
  logic                     prod_vld_q;
  logic signed [ACC_W-1:0]  acc_q;

  logic        [ACC_W:0]    rnd_x;
  logic signed [Q_W-1:0]    q_w;

  assign prod_w = PROD_W'(sample_i) * PROD_W'(coef_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_vld_q <= 1'b0;
    end else begin
      prod_vld_q <= issue_i.en;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= issue_i.keep ? prod_w : '0;
    if (clr_i) begin
      acc_q <= '0;
    end else if (prod_vld_q) begin
      acc_q <= acc_q + ACC_W'(prod_q);
    end
  end

  // floor shift of the sign-extended sum plus one half LSB
  always_comb begin
    rnd_x = {acc_q[ACC_W-1], acc_q} + RND_HALF;
    q_w   = rnd_x[ACC_W:FRAC_SHIFT];
    if (q_w > SAT_HI) begin
      result_o    = SAT_HI[SAMPLE_WIDTH-1:0];
      saturated_o = 1'b1;
    end else if (q_w < SAT_LO) begin
      result_o    = SAT_LO[SAMPLE_WIDTH-1:0];
      saturated_o = 1'b1;
    end else begin
      result_o    = q_w[SAMPLE_WIDTH-1:0];
      saturated_o = 1'b0;
    end
  end

endmodule

[sv/fir_decimator.sv]
// Channel   Dir  Bundle        Carries
// in_i      in   fird_in_if    coefficient loads and samples
// out_o     out  fird_out_if   filtered_sample, saturated
// APB       in   psel..prdata  decimation_factor @0x0, tap_count @0x4
//
// Loads and samples that give no output leave the sequencer in S_IDLE, ready for the next request.
// A sample at phase zero turns the ring of tap cells once past the single multiplier
// at its head, then goes through a drain step and a rounding step.
// No clearing after reset: the fill count masks stale delay-line history.
// A waiting output does not block loads or off-phase samples; the next output
// holds in the rounding step until the output register is free.
`timescale 1ns / 1ps
`include "fir_decimator_assert.svh"

module fir_decimator import fird_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  fird_in_if.sink            in_i,
  fird_out_if.source         out_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [ADDR_W-1:0]  paddr,
  input  logic [DATA_W-1:0]  pwdata,
  output logic [DATA_W-1:0]  prdata,
  output logic               pready
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_RUN,    // ring turning, one product per cycle
    S_DRAIN,  // last product into the accumulator
    S_FINISH  // round and hand to the output register
  } state_e;

  state_e               state_q;
  logic [IDX_W-1:0]     rot_q;      // original tap index now at the ring head
  logic [CNT_W-1:0]     limit_q;    // taps summed for this output
  logic [PHASE_W-1:0]   phase_q;
  logic [FILL_W-1:0]    fill_q;
  logic                 out_valid_q;
  sample_t              out_sample_q;
  logic                 out_sat_q;

  logic [FACTOR_W-1:0]   factor_q;
  logic [TAPS_REG_W-1:0] taps_q;

  // ---------------------------------------------------------------------------
  // APB registers; pready is tied high, so a write lands in the access cycle.
  // ---------------------------------------------------------------------------
  logic       cfg_we;
  logic [0:0] cfg_idx;

  assign pready  = 1'b1;
  assign cfg_we  = psel && penable && pwrite;
  assign cfg_idx = paddr[ADDR_W-1:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      factor_q <= FACTOR_W'(1);
      taps_q   <= TAPS_REG_W'(1);
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_FACTOR: factor_q <= pwdata[FACTOR_W-1:0];
        REG_TAPS:   taps_q   <= pwdata[TAPS_REG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_FACTOR: prdata = DATA_W'(factor_q);
      REG_TAPS:   prdata = DATA_W'(taps_q);
      default:    prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Input requests: effective settings, phase and fill bookkeeping
  // ---------------------------------------------------------------------------
  logic                in_fire;
  logic                smp_fire;
  logic                load_fire;
  logic [FACTOR_W-1:0] factor_eff;
  logic [CNT_W-1:0]    taps_w;
  logic [CNT_W-1:0]    taps_eff;
  logic [PHASE_W-1:0]  phase_cur;
  logic [FACTOR_W-1:0] phase_inc;
  logic [PHASE_W-1:0]  phase_nxt;
  logic [FILL_W-1:0]   fill_cur;
  logic [FILL_W-1:0]   fill_nxt;
  logic [CNT_W-1:0]    limit_nxt;
  logic                emit;

  assign in_i.ready = (state_q == S_IDLE);
  assign in_fire    = in_i.valid && in_i.ready;
  assign smp_fire   = in_fire && (in_i.command == CMD_SAMPLE);
  assign load_fire  = in_fire && (in_i.command == CMD_LOAD);

  always_comb begin
    // out-of-range settings clamp to the nearest legal value
    if (factor_q == '0) begin
      factor_eff = FACTOR_W'(1);
    end else if (factor_q > FACTOR_W'(MAX_FACTOR)) begin
      factor_eff = FACTOR_W'(MAX_FACTOR);
    end else begin
      factor_eff = factor_q;
    end

    taps_w = CNT_W'(taps_q);
    if (taps_w == '0) begin
      taps_eff = CNT_W'(1);
    end else if (taps_w > CNT_W'(MAX_TAPS)) begin
      taps_eff = CNT_W'(MAX_TAPS);
    end else begin
      taps_eff = taps_w;
    end

    // a new signal restarts phase and forgets history
    phase_cur = in_i.first_of_signal ? '0 : phase_q;
    fill_cur  = in_i.first_of_signal ? '0 : fill_q;

    phase_inc = FACTOR_W'(phase_cur) + FACTOR_W'(1);
    phase_nxt = (phase_inc >= factor_eff) ? '0 : phase_inc[PHASE_W-1:0];

    fill_nxt  = (fill_cur < FILL_W'(MAX_TAPS)) ? fill_cur + FILL_W'(1) : fill_cur;
    limit_nxt = (taps_eff < CNT_W'(fill_nxt)) ? taps_eff : CNT_W'(fill_nxt);

    emit = (phase_cur == '0);
  end

  // ---------------------------------------------------------------------------
  // Tap ring: cell 0 holds the newest sample and sits at the multiplier
  // ---------------------------------------------------------------------------
  cell_ctrl_t          cell_ctrl;
  logic [MAX_TAPS-1:0] load_en;
  sample_t             cell_sample [MAX_TAPS];
  coef_t               cell_coef   [MAX_TAPS];

  assign cell_ctrl.push   = smp_fire;
  assign cell_ctrl.rotate = (state_q == S_RUN);

  for (genvar j = 0; j < MAX_TAPS; j++) begin : g_cell
    sample_t shift_in;

    if (j == 0) begin : g_head
      assign shift_in = in_i.sample_value;
    end else begin : g_body
      assign shift_in = cell_sample[j-1];
    end

    // the 7-bit index covers every cell of the ring, so each load lands in exactly one cell
    assign load_en[j] = load_fire && (32'(in_i.coef_index) == 32'(j));

    fird_cell u_cell (
      .clk_i          (clk_i),
      .ctrl_i         (cell_ctrl),
      .load_i         (load_en[j]),
      .load_coef_i    (in_i.coef_value),
      .shift_sample_i (shift_in),
      .ring_sample_i  (cell_sample[(j + 1) % MAX_TAPS]),
      .ring_coef_i    (cell_coef[(j + 1) % MAX_TAPS]),
      .sample_o       (cell_sample[j]),
      .coef_o         (cell_coef[j])
    );
  end

  // ---------------------------------------------------------------------------
  // MAC at the ring head
  // ---------------------------------------------------------------------------
  mac_issue_t mac_issue;
  logic       mac_clr;
  logic       rot_last;
  sample_t    mac_result;
  logic       mac_sat;

  assign rot_last       = (rot_q == IDX_W'(MAX_TAPS - 1));
  assign mac_issue.en   = (state_q == S_RUN);
  assign mac_issue.keep = (state_q == S_RUN) && (CNT_W'(rot_q) < limit_q);
  assign mac_clr        = smp_fire && emit;

  fird_mac u_mac (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .clr_i       (mac_clr),
    .issue_i     (mac_issue),
    .sample_i    (cell_sample[0]),
    .coef_i      (cell_coef[0]),
    .result_o    (mac_result),
    .saturated_o (mac_sat)
  );

  // ---------------------------------------------------------------------------
  // Sequencer and output register
  // ---------------------------------------------------------------------------
  logic out_load;

  // rounding step may hand over when the output register is empty or being claimed
  assign out_load = (state_q == S_FINISH) && (!out_valid_q || out_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      rot_q        <= '0;
      limit_q      <= '0;
      phase_q      <= '0;
      fill_q       <= '0;
      out_valid_q  <= 1'b0;
      out_sample_q <= '0;
      out_sat_q    <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid_q  <= 1'b1;
        out_sample_q <= mac_result;
        out_sat_q    <= mac_sat;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        S_IDLE: begin
          if (smp_fire) begin
            phase_q <= phase_nxt;
            fill_q  <= fill_nxt;
            if (emit) begin
              limit_q <= limit_nxt;
              rot_q   <= '0;
              state_q <= S_RUN;
            end
          end
        end
        S_RUN: begin
          if (rot_last) begin
            rot_q   <= '0;
            state_q <= S_DRAIN;
          end else begin
            rot_q <= rot_q + IDX_W'(1);
          end
        end
        S_DRAIN: begin
          state_q <= S_FINISH;
        end
        S_FINISH: begin
          // wait here while the previous output is still unclaimed
          if (out_load) begin
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign out_o.valid           = out_valid_q;
  assign out_o.filtered_sample = out_sample_q;
  assign out_o.saturated       = out_sat_q;

  // ---------------------------------------------------------------------------
  // Checks
  // ---------------------------------------------------------------------------
  `FIRD_ASSERT_NXT(a_ring_home, state_q == S_RUN && rot_last, state_q == S_DRAIN && rot_q == '0)
  `FIRD_ASSERT_IMP(a_out_from_finish, $rose(out_valid_q), $past(state_q) == S_FINISH)
  `FIRD_ASSERT_IMP(a_limit_range, state_q == S_RUN, limit_q != '0 && limit_q <= CNT_W'(MAX_TAPS))
  `FIRD_ASSERT_NXT(a_emit_starts, smp_fire && emit, state_q == S_RUN && rot_q == '0)

endmodule

[verif/fir_decimator_tb.sv]
`timescale 1ns / 1ps

module fir_decimator_tb;
  import fird_pkg::*;

  // Timing and run length
  localparam int HALF_PERIOD     = 2;
  localparam int RESET_CYCLES    = 12;
  localparam int RANDOM_REQUESTS = 1650;
  // an output walks the whole tap ring, then drains and rounds
  localparam int OUTPUT_CYCLES   = MAX_TAPS + 3;
  localparam int SETTLE_CYCLES   = OUTPUT_CYCLES + 8;
  localparam int HOLDOFF_CYCLES  = 800;
  // well above one output time plus the long receiver hold-off
  localparam int WATCHDOG_LIMIT  = 4000;

  localparam longint OUT_HI = (longint'(1) << (SAMPLE_WIDTH - 1)) - 1;
  localparam longint OUT_LO = -OUT_HI - 1;
  localparam longint ROUND_HALF = longint'(1) << (FRAC_SHIFT - 1);

  localparam sample_t SAMPLE_MAX = {1'b0, {(SAMPLE_WIDTH - 1){1'b1}}};
  localparam sample_t SAMPLE_MIN = {1'b1, {(SAMPLE_WIDTH - 1){1'b0}}};
  localparam coef_t   COEF_MAX   = {1'b0, {(COEF_WIDTH - 1){1'b1}}};
  localparam coef_t   COEF_MIN   = {1'b1, {(COEF_WIDTH - 1){1'b0}}};

  typedef struct packed {
    logic              command;
    sample_t           sample_value;
    logic              first_of_signal;
    logic [CIDX_W-1:0] coef_index;
    coef_t             coef_value;
  } request_t;

  typedef struct packed {
    sample_t value;
    logic    sat;
  } filt_out_t;

  typedef enum logic {STEP_REQUEST, STEP_CONFIG} step_kind_e;

  // One row of the directed table: either a request or a register write.
  // Rows with typed set carry a hand-computed output instead of the predicted one.
  typedef struct {
    step_kind_e        kind;
    request_t          req;
    bit                typed;
    filt_out_t         want;
    logic [0:0]        reg_idx;
    logic [DATA_W-1:0] reg_val;
  } dir_step_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  fird_in_if  in_if ();
  fird_out_if out_if ();

  fir_decimator uut (
    .clk_i   (clk),
    .rst_ni  (rst_n),
    .in_i    (in_if),
    .out_o   (out_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #(HALF_PERIOD) clk = ~clk;

  // ---------------------------------------------------------------------------
  // Filter predictor: its own delay line, coefficient table, phase and fill
  // counters, plus a copy of the two registers.
  // ---------------------------------------------------------------------------
  sample_t                history [MAX_TAPS];
  coef_t                  coef_mem [MAX_TAPS];
  int unsigned            phase_cnt;
  int unsigned            fill_cnt;
  logic [FACTOR_W-1:0]    factor_reg;
  logic [TAPS_REG_W-1:0]  taps_reg;

  filt_out_t expected_outputs [$];

  int errors;
  int n_requests;
  int n_loads;
  int n_samples;
  int n_restarts;
  int n_outputs;
  int n_clipped;
  int n_cfg_writes;
  int burst_left;
  int stall_cycles;
  bit holdoff_req;

  // Advance the predictor by one request; returns 1 when an output is due.
  function automatic bit filter_step(input request_t r, output filt_out_t res);
    int unsigned eff_factor;
    int unsigned eff_taps;
    longint      acc;
    longint      q;
    bit          emit;
    res = '0;
    if (r.command == CMD_LOAD) begin
      // the restart flag means nothing on a load
      coef_mem[r.coef_index] = r.coef_value;
      return 1'b0;
    end
    if (r.first_of_signal) begin
      fill_cnt  = 0;
      phase_cnt = 0;
    end
    for (int k = MAX_TAPS - 1; k > 0; k--) history[k] = history[k-1];
    history[0] = r.sample_value;
    if (fill_cnt < MAX_TAPS) fill_cnt++;

    // factor 0 runs as 1, anything past the maximum runs as the maximum
    eff_factor = (factor_reg == 0) ? 1 :
                 (factor_reg > MAX_FACTOR) ? MAX_FACTOR : factor_reg;
    emit = (phase_cnt == 0);
    phase_cnt++;
    if (phase_cnt >= eff_factor) phase_cnt = 0;
    if (!emit) return 1'b0;

    // same clipping for the tap count; taps older than the signal read as zero
    eff_taps = (taps_reg == 0) ? 1 : (taps_reg > MAX_TAPS) ? MAX_TAPS : taps_reg;
    if (eff_taps > fill_cnt) eff_taps = fill_cnt;
    acc = 0;
    for (int j = 0; j < eff_taps; j++) acc += longint'(coef_mem[j]) * longint'(history[j]);

    // round half up, floor shift to Q1.15, clip with flag
    q = (acc + ROUND_HALF) >>> FRAC_SHIFT;
    if (q > OUT_HI) begin
      res.value = sample_t'(OUT_HI);
      res.sat   = 1'b1;
    end else if (q < OUT_LO) begin
      res.value = sample_t'(OUT_LO);
      res.sat   = 1'b1;
    end else begin
      res.value = sample_t'(q);
      res.sat   = 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic request_t load_req(input int idx, input coef_t val, input logic restart);
    request_t r;
    r.command         = CMD_LOAD;
    r.sample_value    = sample_t'($urandom);
    r.first_of_signal = restart;
    r.coef_index      = CIDX_W'(idx);
    r.coef_value      = val;
    return r;
  endfunction

  function automatic request_t sample_req(input sample_t val, input logic restart);
    request_t r;
    r.command         = CMD_SAMPLE;
    r.sample_value    = val;
    r.first_of_signal = restart;
    r.coef_index      = CIDX_W'($urandom);
    r.coef_value      = coef_t'($urandom);
    return r;
  endfunction

  // Directed table rows
  function automatic dir_step_t load_row(input int idx, input int val, input logic restart);
    dir_step_t s;
    s = '{kind: STEP_REQUEST, req: load_req(idx, coef_t'(val), restart), typed: 1'b0,
          want: '0, reg_idx: REG_FACTOR, reg_val: '0};
    return s;
  endfunction

  function automatic dir_step_t sample_row(input int val, input logic restart);
    dir_step_t s;
    s = '{kind: STEP_REQUEST, req: sample_req(sample_t'(val), restart), typed: 1'b0,
          want: '0, reg_idx: REG_FACTOR, reg_val: '0};
    return s;
  endfunction

  function automatic dir_step_t typed_row(input int val, input logic restart,
                                          input int out_val, input logic out_sat);
    dir_step_t s;
    s = sample_row(val, restart);
    s.typed = 1'b1;
    s.want  = '{value: sample_t'(out_val), sat: out_sat};
    return s;
  endfunction

  function automatic dir_step_t cfg_row(input logic [0:0] idx, input int val);
    dir_step_t s;
    s = '{kind: STEP_CONFIG, req: '0, typed: 1'b0, want: '0, reg_idx: idx,
          reg_val: DATA_W'(val)};
    return s;
  endfunction

  // Mostly small coefficients so that outputs stay in range; some extremes
  // and full-range values to drive the clipping path.
  function automatic coef_t rand_coef();
    case ($urandom_range(0, 9))
      0:       return COEF_MIN;
      1:       return COEF_MAX;
      2, 3:    return coef_t'($urandom);
      default: return coef_t'(int'($urandom_range(0, 8191)) - 4096);
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Request driver: payload and valid change at the falling edge, the
  // handshake is taken at the rising edge, then the predictor runs.
  // ---------------------------------------------------------------------------
  task automatic send_request(input request_t r, input bit typed, input filt_out_t want);
    filt_out_t res;
    bit        emits;
    @(negedge clk);
    in_if.command         <= r.command;
    in_if.sample_value    <= r.sample_value;
    in_if.first_of_signal <= r.first_of_signal;
    in_if.coef_index      <= r.coef_index;
    in_if.coef_value      <= r.coef_value;
    in_if.valid           <= 1'b1;
    do @(posedge clk); while (!in_if.ready);
    emits = filter_step(r, res);
    n_requests++;
    if (r.command == CMD_LOAD) begin
      n_loads++;
    end else begin
      n_samples++;
      if (r.first_of_signal) n_restarts++;
    end
    if (emits) expected_outputs.push_back(typed ? want : res);
  endtask

  // Bursts of random length with random gaps; some gaps are zero, so bursts
  // often run back to back.
  task automatic pace();
    int gap;
    if (burst_left > 0) begin
      burst_left--;
      return;
    end
    case ($urandom_range(0, 9))
      0, 1, 2: gap = 0;
      3:       gap = $urandom_range(15, 40);
      default: gap = $urandom_range(1, 6);
    endcase
    repeat (gap) begin
      @(negedge clk);
      in_if.valid <= 1'b0;
    end
    burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 120) : $urandom_range(1, 24);
  endtask

  task automatic drain_outputs();
    @(negedge clk);
    in_if.valid <= 1'b0;
    while (expected_outputs.size() != 0) @(posedge clk);
  endtask

  // Loads and off-phase samples leave no trace in the output queue, so give
  // the block a full output time after the last output before touching it.
  task automatic settle();
    drain_outputs();
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // APB write followed by a read-back of the same register.
  task automatic write_reg(input logic [0:0] idx, input logic [DATA_W-1:0] value);
    logic [DATA_W-1:0] stored;
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (idx == REG_FACTOR) factor_reg = value[FACTOR_W-1:0];
    else                   taps_reg   = value[TAPS_REG_W-1:0];
    stored = (idx == REG_FACTOR) ? DATA_W'(factor_reg) : DATA_W'(taps_reg);
    n_cfg_writes++;

    @(negedge clk);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== stored) begin
      $display("%0t: register %0d read back: expected %0d, got %0d",
               $time, idx, stored, prdata);
      errors++;
    end
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Receiver: its own stall pattern, switched among four modes at random, plus
  // one long hold-off on request from the stimulus.
  // ---------------------------------------------------------------------------
  initial begin
    int          mode;
    int          mode_left;
    int          hold_left;
    int unsigned tick;
    mode      = 0;
    mode_left = 0;
    hold_left = 0;
    tick      = 0;
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      tick++;
      if (mode_left == 0) begin
        mode      = $urandom_range(0, 3);
        mode_left = $urandom_range(64, 256);
      end
      mode_left--;
      if (holdoff_req) begin
        hold_left   = HOLDOFF_CYCLES;
        holdoff_req = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else begin
        case (mode)
          0:       out_if.ready <= 1'b1;
          1:       out_if.ready <= 1'($urandom_range(0, 1));
          2:       out_if.ready <= ($urandom_range(0, 3) == 0);
          default: out_if.ready <= ((tick % 5) != 0);
        endcase
      end
    end
  end

  // Output checker: every accepted output against the oldest expectation.
  always @(posedge clk) begin
    filt_out_t want;
    if (rst_n && out_if.valid && out_if.ready) begin
      n_outputs++;
      if (expected_outputs.size() == 0) begin
        $display("%0t: output with nothing expected: value %0d sat %0b",
                 $time, out_if.filtered_sample, out_if.saturated);
        errors++;
      end else begin
        want = expected_outputs.pop_front();
        if (want.sat) n_clipped++;
        if (out_if.filtered_sample !== want.value) begin
          $display("%0t: filtered_sample: expected %0d, got %0d",
                   $time, want.value, out_if.filtered_sample);
          errors++;
        end
        if (out_if.saturated !== want.sat) begin
          $display("%0t: saturated: expected %0b, got %0b",
                   $time, want.sat, out_if.saturated);
          errors++;
        end
      end
    end
  end

  // Watchdog: too long without any handshake on any port ends the run.
  always @(posedge clk) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) || (psel && penable)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no progress for %0d cycles, %0d outputs outstanding",
               $time, stall_cycles, expected_outputs.size());
      $display("FAILED: results differ");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  initial begin
    dir_step_t plan [$];
    filt_out_t none;
    request_t  r;
    int        rand_count;
    int        phase_items;
    int        p;
    int        fac;
    int        tap;

    none       = '0;
    rand_count = 0;

    in_if.valid           = 1'b0;
    in_if.command         = CMD_SAMPLE;
    in_if.sample_value    = '0;
    in_if.first_of_signal = 1'b0;
    in_if.coef_index      = '0;
    in_if.coef_value      = '0;
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    paddr   = '0;
    pwdata  = '0;

    // predictor at reset: empty history, factor 1, one tap
    foreach (history[k]) history[k] = '0;
    foreach (coef_mem[k]) coef_mem[k] = '0;
    phase_cnt  = 0;
    fill_cnt   = 0;
    factor_reg = FACTOR_W'(1);
    taps_reg   = TAPS_REG_W'(1);

    repeat (RESET_CYCLES) @(negedge clk);
    rst_n <= 1'b1;

    // --- Directed table -----------------------------------------------------
    // Reset config is one tap at factor 1, so early outputs are just
    // coefficient 0 times the newest sample and can be worked out by hand.
    // The restart flag on the first load must be ignored.
    plan.push_back(load_row(0, 65536, 1'b1));                   // unity gain
    plan.push_back(typed_row(32767, 1'b1, 32767, 1'b0));
    plan.push_back(typed_row(-32768, 1'b0, -32768, 1'b0));
    plan.push_back(load_row(0, 131071, 1'b0));                  // largest coefficient
    plan.push_back(typed_row(32767, 1'b0, 32767, 1'b1));
    plan.push_back(load_row(0, -131072, 1'b0));                 // most negative
    plan.push_back(typed_row(-32768, 1'b0, 32767, 1'b1));
    plan.push_back(typed_row(32767, 1'b0, -32768, 1'b1));
    plan.push_back(typed_row(0, 1'b0, 0, 1'b0));
    plan.push_back(load_row(1, -1, 1'b0));
    plan.push_back(load_row(2, 74565, 1'b0));
    plan.push_back(load_row(3, -77777, 1'b0));
    plan.push_back(load_row(127, 4321, 1'b0));                  // top table entry
    // four taps at factor 2, with a restart in the middle of the signal
    plan.push_back(cfg_row(REG_TAPS, 4));
    plan.push_back(cfg_row(REG_FACTOR, 2));
    plan.push_back(sample_row(1000, 1'b1));
    plan.push_back(sample_row(-2000, 1'b0));
    plan.push_back(sample_row(3000, 1'b0));
    plan.push_back(sample_row(32767, 1'b1));
    plan.push_back(sample_row(-5, 1'b0));
    // zero factor and zero taps both run as one
    plan.push_back(cfg_row(REG_FACTOR, 0));
    plan.push_back(cfg_row(REG_TAPS, 0));
    plan.push_back(sample_row(123, 1'b1));
    plan.push_back(sample_row(-456, 1'b0));
    // both registers past their limits; the fill count keeps reads to loaded taps
    plan.push_back(cfg_row(REG_FACTOR, 127));
    plan.push_back(cfg_row(REG_TAPS, 255));
    plan.push_back(sample_row(7, 1'b1));
    plan.push_back(sample_row(8, 1'b0));
    plan.push_back(sample_row(9, 1'b0));

    foreach (plan[i]) begin
      if (plan[i].kind == STEP_CONFIG) begin
        settle();
        write_reg(plan[i].reg_idx, plan[i].reg_val);
      end else begin
        pace();
        send_request(plan[i].req, plan[i].typed, plan[i].want);
      end
    end

    // --- Random part --------------------------------------------------------
    // Fill the whole coefficient table first so no later tap read hits an
    // entry that was never loaded.
    settle();
    for (int k = 0; k < MAX_TAPS; k++) begin
      pace();
      send_request(load_req(k, rand_coef(), 1'($urandom_range(0, 1))), 1'b0, none);
      rand_count++;
    end

    p = 0;
    while (rand_count < RANDOM_REQUESTS) begin
      // The first phase is random, the second pins the extremes, the hold-off phase
      // uses a fast setting so outputs pile up; later phases mostly pick small factors and taps.
      case (p)
        1: begin
          fac = MAX_FACTOR;
          tap = MAX_TAPS;
        end
        2, 3: begin
          fac = 1;
          tap = (p == 2) ? 1 : 4;
        end
        default: begin
          case ($urandom_range(0, 7))
            0:       fac = 0;
            1:       fac = MAX_FACTOR;
            2:       fac = $urandom_range(MAX_FACTOR + 1, 127);
            3:       fac = $urandom_range(5, MAX_FACTOR - 1);
            default: fac = $urandom_range(1, 4);
          endcase
          case ($urandom_range(0, 7))
            0:       tap = 0;
            1:       tap = MAX_TAPS;
            2:       tap = $urandom_range(MAX_TAPS + 1, 255);
            3:       tap = $urandom_range(17, MAX_TAPS - 1);
            default: tap = $urandom_range(1, 16);
          endcase
        end
      endcase
      settle();
      write_reg(REG_FACTOR, DATA_W'(fac));
      write_reg(REG_TAPS, DATA_W'(tap));

      // receiver goes quiet for a long stretch while requests keep coming
      if (p == 3) holdoff_req = 1'b1;

      phase_items = $urandom_range(60, 140);
      for (int k = 0; k < phase_items; k++) begin
        // once, the sender stops mid-signal until every output is out
        if (p == 5 && k == phase_items / 2) drain_outputs();
        pace();
        if ($urandom_range(0, 6) == 0) begin
          r = load_req($urandom_range(0, MAX_TAPS - 1), rand_coef(), 1'($urandom_range(0, 1)));
        end else begin
          case ($urandom_range(0, 9))
            0:       r = sample_req(SAMPLE_MIN, 1'b0);
            1:       r = sample_req(SAMPLE_MAX, 1'b0);
            default: r = sample_req(sample_t'($urandom), 1'b0);
          endcase
          // most phases open a fresh signal; stray restarts land anywhere
          r.first_of_signal = (k == 0) ? ($urandom_range(0, 3) != 0)
                                       : ($urandom_range(0, 29) == 0);
        end
        send_request(r, 1'b0, none);
        rand_count++;
      end
      p++;
    end

    // --- Wind down ----------------------------------------------------------
    settle();

    $display("Covered %0d requests (%0d loads, %0d samples, %0d restarts), %0d register writes",
             n_requests, n_loads, n_samples, n_restarts, n_cfg_writes);
    $display("over %0d settings; %0d outputs checked, %0d clipped, %0d errors",
             p, n_outputs, n_clipped, errors);
    if (errors == 0 && expected_outputs.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

[fir_decimator.f]
+incdir+sv
sv/fird_pkg.sv
sv/fird_in_if.sv
sv/fird_out_if.sv
sv/fird_cell.sv
sv/fird_mac.sv
sv/fir_decimator.sv
verif/fir_decimator_tb.sv
